// ===== design/hpgs_pkg.sv =====
`timescale 1ns / 1ps

package hpgs_pkg;

  localparam int CUR_W   = 16;
  localparam int STICK_W = 13;
  localparam int SPC_W   = 8;
  localparam int REV_W   = 9;
  localparam int RAD_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic signed [STICK_W-1:0] STICK_MIN = -13'sd4096;
  localparam logic signed [STICK_W-1:0] STICK_MAX = 13'sd4095;

  localparam logic [3:0] HOVER_NONE = 4'd8;

  localparam logic [2:0] GEAR_NEUTRAL = 3'd0;
  localparam logic [2:0] GEAR_1       = 3'd1;
  localparam logic [2:0] GEAR_2       = 3'd2;
  localparam logic [2:0] GEAR_3       = 3'd3;
  localparam logic [2:0] GEAR_4       = 3'd4;
  localparam logic [2:0] GEAR_5       = 3'd5;
  localparam logic [2:0] GEAR_6       = 3'd6;
  localparam logic [2:0] GEAR_REV     = 3'd7;

  localparam logic [SPC_W-1:0] SPACING_X_RST = 8'd60;
  localparam logic [SPC_W-1:0] SPACING_Y_RST = 8'd60;
  localparam logic [REV_W-1:0] REV_X_RST     = 9'd108;
  localparam logic [RAD_W-1:0] SLOT_RAD_RST  = 8'd30;
  localparam logic [RAD_W-1:0] NEUT_RAD_RST  = 8'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPACING_X = 3'd0,
    CFG_SPACING_Y = 3'd1,
    CFG_REV_X     = 3'd2,
    CFG_SLOT_RAD  = 3'd3,
    CFG_NEUT_RAD  = 3'd4
  } cfg_reg_e;

endpackage

// ===== design/hpgs_in_if.sv =====
`timescale 1ns / 1ps

interface hpgs_in_if import hpgs_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [CUR_W-1:0] cursor_x;
  logic signed [CUR_W-1:0] cursor_y;
  logic                    button_down;
  logic                    shifter_on;

  modport source (output valid, output cursor_x, output cursor_y, output button_down,
                  output shifter_on, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input button_down,
                input shifter_on, output ready);
endinterface

// ===== design/hpgs_out_if.sv =====
`timescale 1ns / 1ps

interface hpgs_out_if import hpgs_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [3:0]                hovered_gear;
  logic [2:0]                engaged_gear;
  logic                      gear_changed;
  logic signed [STICK_W-1:0] stick_x;
  logic signed [STICK_W-1:0] stick_y;

  modport source (output valid, output hovered_gear, output engaged_gear,
                  output gear_changed, output stick_x, output stick_y, input ready);
  modport sink (input valid, input hovered_gear, input engaged_gear,
                input gear_changed, input stick_x, input stick_y, output ready);
endinterface

// ===== design/hpgs_cfg_if.sv =====
`timescale 1ns / 1ps

interface hpgs_cfg_if import hpgs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/h_pattern_gear_selector.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Payload                                                   | Transaction
// in_i    | in  | cursor_x, cursor_y, button_down, shifter_on              | valid & ready
// out_o   | out | hovered_gear, engaged_gear, gear_changed, stick_x/y     | valid & ready
// cfg_i   | in  | index (0..4 used), data                                   | valid & ready
//
// One tick per cycle unless the result stalls: input register, one pass of logic, result register.
// Result valid rises as a tick moves from the input register into the result register.
// The seven squared-distance lanes (7 multipliers, 13x13) set the critical path.
// Async active-low reset clears control and gear state; config registers take reset values.
// A stalled result holds the state registers; one more tick waits in the input register.
// cfg_i is always ready.

module h_pattern_gear_selector import hpgs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hpgs_in_if.sink     in_i,
  hpgs_out_if.source  out_o,
  hpgs_cfg_if.sink    cfg_i
);

  logic [SPC_W-1:0] spc_x_q, spc_y_q;
  logic [REV_W-1:0] rev_x_q;
  logic [RAD_W-1:0] slot_rad_q, neut_rad_q;

  logic                    in_valid_q;
  logic signed [CUR_W-1:0] cur_x_q, cur_y_q;
  logic                    button_q, enable_q;

  logic signed [STICK_W-1:0] stick_x_q, stick_y_q, stick_x_d, stick_y_d;
  logic                      grab_q, latched_q, latched_d;
  logic [3:0]                hover_q, hover_d;
  logic [2:0]                gear_q, gear_d;
  logic signed [CUR_W-1:0]   prev_x_q, prev_y_q, prev_x_d, prev_y_d;
  logic                      out_valid_q, changed_q, changed_d;

  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_x_q    <= SPACING_X_RST;
      spc_y_q    <= SPACING_Y_RST;
      rev_x_q    <= REV_X_RST;
      slot_rad_q <= SLOT_RAD_RST;
      neut_rad_q <= NEUT_RAD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_SPACING_X: spc_x_q    <= cfg_i.data[SPC_W-1:0];
        CFG_SPACING_Y: spc_y_q    <= cfg_i.data[SPC_W-1:0];
        CFG_REV_X:     rev_x_q    <= cfg_i.data[REV_W-1:0];
        CFG_SLOT_RAD:  slot_rad_q <= cfg_i.data[RAD_W-1:0];
        CFG_NEUT_RAD:  neut_rad_q <= cfg_i.data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      cur_x_q  <= in_i.cursor_x;
      cur_y_q  <= in_i.cursor_y;
      button_q <= in_i.button_down;
      enable_q <= in_i.shifter_on;
    end
  end

  function automatic logic [25:0] sq(input logic signed [13:0] v);
    logic [12:0] a;
    a = v[13] ? 13'(-v) : v[12:0];
    return 26'(a) * 26'(a);
  endfunction

  function automatic logic signed [STICK_W-1:0] clamp(input logic signed [17:0] v);
    if (v < 18'(STICK_MIN)) begin
      return STICK_MIN;
    end else if (v > 18'(STICK_MAX)) begin
      return STICK_MAX;
    end
    return v[STICK_W-1:0];
  endfunction

  logic                      release_w, track, grab_start, latched_eff;
  logic [2:0]                target;
  logic signed [STICK_W-1:0] slot_x, slot_y, base_x, base_y, cl_x, cl_y;
  logic signed [CUR_W:0]     dlt_x, dlt_y;
  logic signed [13:0]        sx, sy, rx;
  logic [25:0]               qxm, qx0, qxp, qxr, qym, qy0, qyp;
  logic [26:0]               rr_slot, rr_neut;
  logic [3:0]                hover_new;

  always_comb begin
    grab_start  = button_q && !grab_q;
    release_w   = !button_q && grab_q;
    track       = enable_q && button_q;
    latched_eff = grab_q && latched_q;
    target      = (hover_q <= 4'(GEAR_REV)) ? hover_q[2:0] : GEAR_NEUTRAL;

    sx = 14'(spc_x_q);
    sy = 14'(spc_y_q);
    rx = 14'(rev_x_q);

    case (target)
      GEAR_1:   begin slot_x = -13'(sx); slot_y = -13'(sy); end
      GEAR_2:   begin slot_x = -13'(sx); slot_y = 13'(sy);  end
      GEAR_3:   begin slot_x = '0;       slot_y = -13'(sy); end
      GEAR_4:   begin slot_x = '0;       slot_y = 13'(sy);  end
      GEAR_5:   begin slot_x = 13'(sx);  slot_y = -13'(sy); end
      GEAR_6:   begin slot_x = 13'(sx);  slot_y = 13'(sy);  end
      GEAR_REV: begin slot_x = -13'(rx); slot_y = -13'(sy); end
      default:  begin slot_x = '0;       slot_y = '0;       end
    endcase

    base_x = release_w ? slot_x : stick_x_q;
    base_y = release_w ? slot_y : stick_y_q;

    dlt_x = latched_eff ? ({cur_x_q[CUR_W-1], cur_x_q} - {prev_x_q[CUR_W-1], prev_x_q}) : '0;
    dlt_y = latched_eff ? ({cur_y_q[CUR_W-1], cur_y_q} - {prev_y_q[CUR_W-1], prev_y_q}) : '0;

    cl_x = clamp(18'(base_x) + 18'(dlt_x));
    cl_y = clamp(18'(base_y) + 18'(dlt_y));

    // squared distances, shared per column and row
    qxm = sq(14'(cl_x) + sx);
    qx0 = sq(14'(cl_x));
    qxp = sq(14'(cl_x) - sx);
    qxr = sq(14'(cl_x) + rx);
    qym = sq(14'(cl_y) + sy);
    qy0 = sq(14'(cl_y));
    qyp = sq(14'(cl_y) - sy);

    rr_slot = 27'(slot_rad_q) * 27'(slot_rad_q);
    rr_neut = 27'(neut_rad_q) * 27'(neut_rad_q);

    if      ((27'(qxm) + 27'(qym)) < rr_slot) hover_new = 4'(GEAR_1);
    else if ((27'(qxm) + 27'(qyp)) < rr_slot) hover_new = 4'(GEAR_2);
    else if ((27'(qx0) + 27'(qym)) < rr_slot) hover_new = 4'(GEAR_3);
    else if ((27'(qx0) + 27'(qyp)) < rr_slot) hover_new = 4'(GEAR_4);
    else if ((27'(qxp) + 27'(qym)) < rr_slot) hover_new = 4'(GEAR_5);
    else if ((27'(qxp) + 27'(qyp)) < rr_slot) hover_new = 4'(GEAR_6);
    else if ((27'(qxr) + 27'(qym)) < rr_slot) hover_new = 4'(GEAR_REV);
    else if ((27'(qx0) + 27'(qy0)) < rr_neut) hover_new = 4'(GEAR_NEUTRAL);
    else                                      hover_new = HOVER_NONE;

    stick_x_d = track ? cl_x : base_x;
    stick_y_d = track ? cl_y : base_y;
    hover_d   = track ? hover_new : hover_q;
    prev_x_d  = track ? cur_x_q : prev_x_q;
    prev_y_d  = track ? cur_y_q : prev_y_q;
    latched_d = track ? 1'b1 : (grab_start ? 1'b0 : latched_q);
    gear_d    = release_w ? target : gear_q;
    changed_d = release_w && (target != gear_q);
  end

  // state doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stick_x_q   <= '0;
      stick_y_q   <= '0;
      grab_q      <= 1'b0;
      latched_q   <= 1'b0;
      hover_q     <= HOVER_NONE;
      gear_q      <= GEAR_NEUTRAL;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        stick_x_q <= stick_x_d;
        stick_y_q <= stick_y_d;
        grab_q    <= button_q;
        latched_q <= latched_d;
        hover_q   <= hover_d;
        gear_q    <= gear_d;
        prev_x_q  <= prev_x_d;
        prev_y_q  <= prev_y_d;
        changed_q <= changed_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.hovered_gear = hover_q;
  assign out_o.engaged_gear = gear_q;
  assign out_o.gear_changed = changed_q;
  assign out_o.stick_x      = stick_x_q;
  assign out_o.stick_y      = stick_y_q;

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input register dropped a waiting tick");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (gear_q != $past(gear_q)) == changed_q)
    else $error("gear_changed disagrees with engaged gear update");

  a_hover_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> hover_q <= HOVER_NONE)
    else $error("hovered gear code out of range");

  a_release_clears_grab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !button_q |=> !grab_q)
    else $error("grab still active after release");

endmodule

// ===== tb/tb_h_pattern_gear_selector.sv =====
`timescale 1ns / 1ps

module tb_h_pattern_gear_selector;
  import hpgs_pkg::*;

  localparam int CFG_NUM_REGS = 5;
  localparam int PHASE_TICKS  = 75;
  localparam int DRILL_LEN    = 25;

  typedef struct packed {
    logic [3:0]                hovered;
    logic [2:0]                engaged;
    logic                      changed;
    logic signed [STICK_W-1:0] sx;
    logic signed [STICK_W-1:0] sy;
  } gear_report_t;

  typedef struct packed {
    logic signed [CUR_W-1:0] x;
    logic signed [CUR_W-1:0] y;
    logic                    btn;
    logic                    en;
    logic                    pinned;
    gear_report_t            rpt;
  } drill_row_t;

  // Reset settings throughout. Pinned rows carry their report by hand.
  localparam drill_row_t DRILL [DRILL_LEN] = '{
    '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1,
      '{HOVER_NONE, GEAR_NEUTRAL, 1'b0, 13'sd0, 13'sd0}},
    '{16'sd100, 16'sd200, 1'b1, 1'b1, 1'b1,
      '{4'(GEAR_NEUTRAL), GEAR_NEUTRAL, 1'b0, 13'sd0, 13'sd0}},
    '{16'sd40, 16'sd140, 1'b1, 1'b1, 1'b1,
      '{4'(GEAR_1), GEAR_NEUTRAL, 1'b0, -13'sd60, -13'sd60}},
    '{16'sd40, 16'sd140, 1'b0, 1'b1, 1'b1,
      '{4'(GEAR_1), GEAR_1, 1'b1, -13'sd60, -13'sd60}},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b1,
      '{4'(GEAR_1), GEAR_1, 1'b0, -13'sd60, -13'sd60}},
    '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, 1'b1,
      '{HOVER_NONE, GEAR_1, 1'b0, STICK_MAX, STICK_MAX}},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b1, 1'b1,
      '{HOVER_NONE, GEAR_1, 1'b0, STICK_MIN, STICK_MIN}},
    '{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1,
      '{HOVER_NONE, GEAR_NEUTRAL, 1'b1, 13'sd0, 13'sd0}},
    '{16'sd5, 16'sd5, 1'b1, 1'b0, 1'b1,
      '{HOVER_NONE, GEAR_NEUTRAL, 1'b0, 13'sd0, 13'sd0}},
    '{16'sd5, 16'sd5, 1'b0, 1'b0, 1'b1,
      '{HOVER_NONE, GEAR_NEUTRAL, 1'b0, 13'sd0, 13'sd0}},
    '{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1,
      '{4'(GEAR_NEUTRAL), GEAR_NEUTRAL, 1'b0, 13'sd0, 13'sd0}},
    '{16'sd500, -16'sd500, 1'b1, 1'b0, 1'b1,
      '{4'(GEAR_NEUTRAL), GEAR_NEUTRAL, 1'b0, 13'sd0, 13'sd0}},
    '{16'sd60, -16'sd60, 1'b1, 1'b1, 1'b1,
      '{4'(GEAR_5), GEAR_NEUTRAL, 1'b0, 13'sd60, -13'sd60}},
    '{16'sd60, -16'sd60, 1'b0, 1'b1, 1'b1,
      '{4'(GEAR_5), GEAR_5, 1'b1, 13'sd60, -13'sd60}},
    '{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b1,
      '{4'(GEAR_5), GEAR_5, 1'b0, 13'sd60, -13'sd60}},
    '{-16'sd168, 16'sd0, 1'b1, 1'b1, 1'b1,
      '{4'(GEAR_REV), GEAR_5, 1'b0, -13'sd108, -13'sd60}},
    '{-16'sd168, 16'sd0, 1'b0, 1'b0, 1'b1,
      '{4'(GEAR_REV), GEAR_REV, 1'b1, -13'sd108, -13'sd60}},
    '{16'sd3, 16'sd3, 1'b1, 1'b0, 1'b1,
      '{4'(GEAR_REV), GEAR_REV, 1'b0, -13'sd108, -13'sd60}},
    '{16'sd3, 16'sd3, 1'b0, 1'b0, 1'b1,
      '{4'(GEAR_REV), GEAR_REV, 1'b0, -13'sd108, -13'sd60}},
    '{16'sd1000, 16'sd1000, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd1108, 16'sd1120, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd1168, 16'sd1120, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd1048, 16'sd1120, 1'b1, 1'b1, 1'b0, '0},
    '{16'sd1048, 16'sd1120, 1'b0, 1'b1, 1'b0, '0},
    '{-16'sd1, -16'sd1, 1'b0, 1'b1, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  hpgs_in_if  in_if ();
  hpgs_out_if out_if ();
  hpgs_cfg_if cfg_if ();

  h_pattern_gear_selector dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // predictor configuration
  logic [SPC_W-1:0] spc_x = SPACING_X_RST;
  logic [SPC_W-1:0] spc_y = SPACING_Y_RST;
  logic [REV_W-1:0] rev_x = REV_X_RST;
  logic [RAD_W-1:0] slot_rad = SLOT_RAD_RST;
  logic [RAD_W-1:0] neut_rad = NEUT_RAD_RST;

  // predictor state
  int         lever_x = 0;
  int         lever_y = 0;
  logic       grabbing = 1'b0;
  logic       latched = 1'b0;
  logic [3:0] hover = HOVER_NONE;
  logic [2:0] gear = GEAR_NEUTRAL;
  int         last_cx = 0;
  int         last_cy = 0;

  gear_report_t reports_due[$];
  int           mismatches = 0;
  int           phase_ticks = 0;
  bit           bursts_on = 1'b1;
  int           stall_left = 0;

  function automatic void slot_center(input logic [2:0] g, output int cx, output int cy);
    int sx, sy;
    sx = int'(spc_x);
    sy = int'(spc_y);
    case (g)
      GEAR_1:   begin cx = -sx; cy = -sy; end
      GEAR_2:   begin cx = -sx; cy = sy; end
      GEAR_3:   begin cx = 0; cy = -sy; end
      GEAR_4:   begin cx = 0; cy = sy; end
      GEAR_5:   begin cx = sx; cy = -sy; end
      GEAR_6:   begin cx = sx; cy = sy; end
      GEAR_REV: begin cx = -int'(rev_x); cy = -sy; end
      default:  begin cx = 0; cy = 0; end
    endcase
  endfunction

  function automatic bit in_zone(input int px, py, cx, cy, r);
    longint dx, dy;
    dx = longint'(px) - cx;
    dy = longint'(py) - cy;
    return dx * dx + dy * dy < longint'(r) * longint'(r);
  endfunction

  function automatic logic [3:0] find_hover();
    int cx, cy;
    for (int g = int'(GEAR_1); g <= int'(GEAR_REV); g++) begin
      slot_center(3'(g), cx, cy);
      if (in_zone(lever_x, lever_y, cx, cy, int'(slot_rad))) return 4'(g);
    end
    if (in_zone(lever_x, lever_y, 0, 0, int'(neut_rad))) return 4'(GEAR_NEUTRAL);
    return HOVER_NONE;
  endfunction

  function automatic int clamp_stick(input int v);
    if (v < int'(STICK_MIN)) return int'(STICK_MIN);
    if (v > int'(STICK_MAX)) return int'(STICK_MAX);
    return v;
  endfunction

  function automatic logic signed [CUR_W-1:0] to_cursor(input int v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7FFF;
    return CUR_W'(v);
  endfunction

  function automatic gear_report_t lever_step(input logic signed [CUR_W-1:0] cx, cy,
                                              input logic btn, en);
    gear_report_t r;
    logic [2:0]   target;
    r.changed = 1'b0;
    if (btn) begin
      if (!grabbing) begin
        grabbing = 1'b1;
        latched  = 1'b0;
      end
    end else if (grabbing) begin
      target   = (hover <= 4'(GEAR_REV)) ? hover[2:0] : GEAR_NEUTRAL;
      grabbing = 1'b0;
      if (target != gear) begin
        gear      = target;
        r.changed = 1'b1;
      end
      slot_center(gear, lever_x, lever_y);
    end
    if (en && grabbing) begin
      if (!latched) begin
        last_cx = int'(cx);
        last_cy = int'(cy);
        latched = 1'b1;
      end
      lever_x = clamp_stick(lever_x + int'(cx) - last_cx);
      lever_y = clamp_stick(lever_y + int'(cy) - last_cy);
      last_cx = int'(cx);
      last_cy = int'(cy);
      hover   = find_hover();
    end
    r.hovered = hover;
    r.engaged = gear;
    r.sx      = STICK_W'(lever_x);
    r.sy      = STICK_W'(lever_y);
    return r;
  endfunction

  task automatic send_tick(input int cx, cy, input logic btn, en,
                           input logic pinned = 1'b0, input gear_report_t pinned_rpt = '0);
    gear_report_t r;
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cursor_x    <= to_cursor(cx);
    in_if.cursor_y    <= to_cursor(cy);
    in_if.button_down <= btn;
    in_if.shifter_on  <= en;
    do @(posedge clk_i); while (!in_if.ready);
    r = lever_step(to_cursor(cx), to_cursor(cy), btn, en);
    reports_due.push_back(pinned ? pinned_rpt : r);
    phase_ticks++;
    @(negedge clk_i);
  endtask

  // grab, steer toward a slot with some scatter, release
  task automatic shift_gesture();
    logic [2:0] goal;
    int         gx, gy, reach, steps, cx, cy;
    logic       en;
    goal = 3'($urandom_range(0, 7));
    slot_center(goal, gx, gy);
    reach = int'(goal == GEAR_NEUTRAL ? neut_rad : slot_rad) + 2;
    gx += int'($urandom_range(0, 2 * reach)) - reach;
    gy += int'($urandom_range(0, 2 * reach)) - reach;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    send_tick(cx, cy, 1'b1, $urandom_range(0, 7) != 0);
    steps = $urandom_range(1, 4);
    for (int s = steps; s >= 1; s--) begin
      en = $urandom_range(0, 9) != 0;
      if (latched) begin
        cx = last_cx + (gx - lever_x) / s;
        cy = last_cy + (gy - lever_y) / s;
      end else begin
        cx = int'($urandom_range(0, 65535)) - 32768;
        cy = int'($urandom_range(0, 65535)) - 32768;
      end
      send_tick(cx, cy, 1'b1, en);
    end
    if ($urandom_range(0, 15) == 0) begin
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      send_tick(cx, cy, 1'b1, 1'b1);
    end
    send_tick(cx, cy, 1'b0, $urandom_range(0, 1) != 0);
  endtask

  task automatic run_phase(input int n);
    phase_ticks = 0;
    while (phase_ticks < n) begin
      if ($urandom_range(0, 4) == 0)
        send_tick(int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 65535)) - 32768,
                  $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
      else
        shift_gesture();
    end
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_SPACING_X: spc_x = data[SPC_W-1:0];
      CFG_SPACING_Y: spc_y = data[SPC_W-1:0];
      CFG_REV_X:     rev_x = data[REV_W-1:0];
      CFG_SLOT_RAD:  slot_rad = data[RAD_W-1:0];
      CFG_NEUT_RAD:  neut_rad = data[RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] sx, sy, rx, sr, nr);
    write_reg(CFG_SPACING_X, sx);
    write_reg(CFG_SPACING_Y, sy);
    write_reg(CFG_REV_X, rx);
    write_reg(CFG_SLOT_RAD, sr);
    write_reg(CFG_NEUT_RAD, nr);
    cfg_if.valid <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (bursts_on && $urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 10);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    gear_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (reports_due.size() == 0) begin
        $error("result transaction with nothing pending: hovered_gear %0d engaged_gear %0d",
               out_if.hovered_gear, out_if.engaged_gear);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        if (out_if.hovered_gear !== want.hovered) begin
          $error("hovered_gear: expected %0d, actual %0d", want.hovered, out_if.hovered_gear);
          mismatches++;
        end
        if (out_if.engaged_gear !== want.engaged) begin
          $error("engaged_gear: expected %0d, actual %0d", want.engaged, out_if.engaged_gear);
          mismatches++;
        end
        if (out_if.gear_changed !== want.changed) begin
          $error("gear_changed: expected %0d, actual %0d", want.changed, out_if.gear_changed);
          mismatches++;
        end
        if (out_if.stick_x !== want.sx) begin
          $error("stick_x: expected %0d, actual %0d", want.sx, out_if.stick_x);
          mismatches++;
        end
        if (out_if.stick_y !== want.sy) begin
          $error("stick_y: expected %0d, actual %0d", want.sy, out_if.stick_y);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL h_pattern_gear_selector");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cursor_x    = '0;
    in_if.cursor_y    = '0;
    in_if.button_down = 1'b0;
    in_if.shifter_on  = 1'b0;
    out_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DRILL_LEN; i++)
      send_tick(DRILL[i].x, DRILL[i].y, DRILL[i].btn, DRILL[i].en, DRILL[i].pinned, DRILL[i].rpt);
    run_phase(PHASE_TICKS);
    settle();

    apply_settings(9'd255, 9'd255, 9'd511, 9'd255, 9'd255);
    run_phase(PHASE_TICKS);
    settle();

    apply_settings(9'd1, 9'd1, 9'd1, 9'd1, 9'd1);
    run_phase(PHASE_TICKS);
    settle();

    // stacked slots, dead neutral, upper data bit dropped, unused indices
    write_reg(CFG_SPACING_X, 9'h100);
    write_reg(CFG_SPACING_Y, '0);
    write_reg(CFG_REV_X, '0);
    write_reg(CFG_SLOT_RAD, 9'd50);
    write_reg(CFG_NEUT_RAD, '0);
    write_reg(CFG_IDX_W'(CFG_NUM_REGS), 9'h1FF);
    write_reg(CFG_IDX_W'(CFG_NUM_REGS + 2), 9'h055);
    cfg_if.valid <= 1'b0;
    run_phase(PHASE_TICKS);
    settle();

    apply_settings(9'd30, 9'd90, 9'd200, 9'd0, 9'd200);
    run_phase(PHASE_TICKS);
    settle();

    repeat (3) begin
      for (int i = 0; i < CFG_NUM_REGS; i++)
        if ($urandom_range(0, 3) != 0) write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom_range(0, 511)));
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(CFG_NUM_REGS, 7)), CFG_DATA_W'($urandom_range(0, 511)));
      cfg_if.valid <= 1'b0;
      run_phase(PHASE_TICKS);
      settle();
    end

    bursts_on = 1'b0;
    apply_settings(9'(SPACING_X_RST), 9'(SPACING_Y_RST), 9'(REV_X_RST),
                   9'(SLOT_RAD_RST), 9'(NEUT_RAD_RST));
    run_phase(PHASE_TICKS);
    settle();

    if (mismatches == 0)
      $display("PASS h_pattern_gear_selector");
    else
      $display("FAIL h_pattern_gear_selector");
    $finish;
  end

endmodule

// ===== files.f =====
design/hpgs_pkg.sv
design/hpgs_in_if.sv
design/hpgs_out_if.sv
design/hpgs_cfg_if.sv
design/h_pattern_gear_selector.sv
tb/tb_h_pattern_gear_selector.sv
